[rtl/core/atc_pkg.sv]
`timescale 1ns / 1ps

package atc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned MAT_DEPTH     = 12;
  localparam int unsigned ACC_W         = 66;

  typedef enum logic [1:0] {
    KIND_IDENT  = 2'd0,
    KIND_TRANS  = 2'd1,
    KIND_SCALE  = 2'd2,
    KIND_VERTEX = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRANS,
    S_PREP,
    S_MUL,
    S_ACC,
    S_FIN,
    S_OUT
  } state_e;

  typedef logic signed [31:0]      word_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic acc_t sext_word(input word_t w);
    return {{(ACC_W - 32){w[31]}}, w};
  endfunction

  function automatic word_t sat_word(input acc_t v);
    word_t res;
    if (!v[ACC_W-1] && (|v[ACC_W-2:31])) begin
      res = 32'sh7fff_ffff;
    end else if (v[ACC_W-1] && !(&v[ACC_W-2:31])) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/affine_transform_composer_top.sv]
`timescale 1ns / 1ps

// Composite 3D affine transform (top three rows of a 4x4 homogeneous
// matrix, Q16.16 by default), column-vector convention: each transform
// premultiplies the stored matrix.
// Input channel (in_valid_i / in_ready_o): kind_i selects identity reset,
// translate, scale about point (fx/fy/fz) or vertex transform (ax/ay/az).
// Output channel (out_valid_o / out_ready_i): one item per vertex transform.
// All products go through a single 32x32 multiplier, registered, followed
// by a 66-bit accumulator, under a small sequencer.
// A scale works row by row: setup, fixed-point term, four entries.
// A vertex works row by row: three products, then the translation column
// is added and the row result is stored; then the output register loads.
// The result sits in an output register: a new item is taken while it
// waits; a following vertex result waits in the sequencer until the
// receiver takes the earlier one, and input is held off meanwhile.
// Reset loads the identity matrix and empties the output register.
module affine_transform_composer_top #(
  parameter int unsigned FracBits = atc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic signed [31:0]  ax_i,
  input  logic signed [31:0]  ay_i,
  input  logic signed [31:0]  az_i,
  input  logic signed [31:0]  fx_i,
  input  logic signed [31:0]  fy_i,
  input  logic signed [31:0]  fz_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o
);
  import atc_pkg::*;

  localparam word_t One   = 32'sd1 <<< FracBits;
  localparam acc_t  OneW  = sext_word(One);

  state_e state_q, state_d;
  kind_e  kind_q;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  logic       kph_q, kph_d;
  logic       out_valid_q;

  word_t a_q [3];
  word_t f_q [3];
  word_t res_q [3];
  word_t mat_q [MAT_DEPTH];
  word_t d_q, k_q;
  logic signed [63:0] prod_q;
  acc_t  acc_q;
  word_t out_x_q, out_y_q, out_z_q;

  logic  in_acc, out_load;
  logic  group_last;
  word_t mat_rd, a_sel, opa, opb, extra, fin_res;
  logic [1:0] a_idx;

  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // single read port: entry {row, col}
  assign mat_rd = mat_q[{row_q, col_q}];
  assign a_idx  = (kind_q == KIND_VERTEX) ? col_q : row_q;
  assign a_sel  = a_q[a_idx];

  always_comb begin
    if (kind_q == KIND_VERTEX) begin
      opa = mat_rd;
      opb = a_sel;
    end else if (kph_q) begin
      opa = d_q;
      opb = f_q[row_q];
    end else begin
      opa = a_sel;
      opb = mat_rd;
    end
  end

  assign group_last = (kind_q != KIND_VERTEX) || (col_q == 2'd2);

  // translation column is added after the shift; col is 3 here for vertex
  always_comb begin
    if (kind_q == KIND_VERTEX) begin
      extra = mat_rd;
    end else if (!kph_q && (col_q == 2'd3)) begin
      extra = k_q;
    end else begin
      extra = '0;
    end
  end

  assign fin_res  = sat_word((acc_q >>> FracBits) + sext_word(extra));
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      kph_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      kph_q   <= kph_d;
    end
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    kph_d   = kph_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          row_d = '0;
          col_d = '0;
          kph_d = 1'b0;
          unique case (kind_e'(kind_i))
            KIND_IDENT:  state_d = S_IDLE;
            KIND_TRANS: begin
              col_d   = 2'd3;
              state_d = S_TRANS;
            end
            KIND_SCALE:  state_d = S_PREP;
            KIND_VERTEX: state_d = S_MUL;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_TRANS: begin
        row_d = row_q + 2'd1;
        if (row_q == 2'd2) begin
          state_d = S_IDLE;
        end
      end
      S_PREP: begin
        kph_d   = 1'b1;
        col_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (group_last) begin
          if (kind_q == KIND_VERTEX) begin
            col_d = 2'd3;
          end
          state_d = S_FIN;
        end else begin
          col_d   = col_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (kind_q == KIND_VERTEX) begin
          col_d = '0;
          if (row_q == 2'd2) begin
            state_d = S_OUT;
          end else begin
            row_d   = row_q + 2'd1;
            state_d = S_MUL;
          end
        end else if (kph_q) begin
          kph_d   = 1'b0;
          col_d   = '0;
          state_d = S_MUL;
        end else if (col_q == 2'd3) begin
          if (row_q == 2'd2) begin
            state_d = S_IDLE;
          end else begin
            row_d   = row_q + 2'd1;
            state_d = S_PREP;
          end
        end else begin
          col_d   = col_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // matrix state, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_DEPTH; i++) begin
        mat_q[i] <= ((i >> 2) == (i & 3)) ? One : '0;
      end
    end else if (in_acc && (kind_e'(kind_i) == KIND_IDENT)) begin
      for (int i = 0; i < MAT_DEPTH; i++) begin
        mat_q[i] <= ((i >> 2) == (i & 3)) ? One : '0;
      end
    end else if (state_q == S_TRANS) begin
      mat_q[{row_q, col_q}] <= sat_word(sext_word(mat_rd) + sext_word(a_sel));
    end else if ((state_q == S_FIN) && (kind_q == KIND_SCALE) && !kph_q) begin
      mat_q[{row_q, col_q}] <= fin_res;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_e'(kind_i);
      a_q[0] <= ax_i;
      a_q[1] <= ay_i;
      a_q[2] <= az_i;
      f_q[0] <= fx_i;
      f_q[1] <= fy_i;
      f_q[2] <= fz_i;
      acc_q  <= '0;
    end
    case (state_q)
      S_PREP: d_q <= sat_word(OneW - sext_word(a_sel));
      S_MUL:  prod_q <= opa * opb;
      S_ACC:  acc_q <= acc_q + {{(ACC_W - 64){prod_q[63]}}, prod_q};
      S_FIN: begin
        acc_q <= '0;
        if (kind_q == KIND_VERTEX) begin
          res_q[row_q] <= fin_res;
        end else if (kph_q) begin
          k_q <= fin_res;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_x_q <= res_q[0];
      out_y_q <= res_q[1];
      out_z_q <= res_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

endmodule

[rtl/core/atc_checker.sv]
`timescale 1ns / 1ps

module atc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          kind_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [31:0]  out_x_o,
  input logic signed [31:0]  out_y_o,
  input logic signed [31:0]  out_z_o
);
  import atc_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o))
    else $error("output item changed while stalled");

  // anything but an identity reset keeps the sequencer busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i != KIND_IDENT) |=> !in_ready_o)
    else $error("input ready right after a multi-cycle item");

  // an identity reset leaves the input ready again in the next cycle
  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_IDENT) |=> in_ready_o)
    else $error("identity reset did not finish in one cycle");

  // only a vertex transform produces an output item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i != KIND_VERTEX) |=> !$rose(out_valid_o))
    else $error("output item appeared after a non-vertex item");

endmodule

bind affine_transform_composer_top atc_checker u_atc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o)
);

[tb/tb_affine_transform_composer_top.sv]
`timescale 1ns / 1ps

module tb_affine_transform_composer_top;
  import atc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int N_ITEMS = 1200;
  localparam int TAIL_ITEMS = 100;      // no idling once this few items are left
  localparam int STALL_LIMIT = 4000;    // cycles without any handshake
  localparam int DRAIN_CYCLES = 60;     // longer than a scale item

  localparam word_t Q_ONE = 32'sh0001_0000;
  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;

  typedef logic signed [69:0] wide_t;
  localparam wide_t WIDE_MAX = 70'sd2147483647;
  localparam wide_t WIDE_MIN = -70'sd2147483648;
  localparam wide_t UNIT = 70'sd1 << FRAC;

  typedef struct packed {
    kind_e kind;
    word_t ax, ay, az;
    word_t fx, fy, fz;
    logic  drain;       // hold this item until no result is outstanding
  } xform_cmd_t;

  typedef struct packed {
    word_t x, y, z;
  } coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = 2'b00;
  logic signed [31:0] ax_i = '0;
  logic signed [31:0] ay_i = '0;
  logic signed [31:0] az_i = '0;
  logic signed [31:0] fx_i = '0;
  logic signed [31:0] fy_i = '0;
  logic signed [31:0] fz_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;

  xform_cmd_t pending_cmds[$];
  coord_t expected_coords[$];
  word_t composite[12];

  int mismatches = 0;
  int in_gap = 0;
  int out_gap = 0;
  int in_idle_pct = 20;
  int out_idle_pct = 20;
  int stall_cycles = 0;
  bit in_accepted = 1'b0;

  affine_transform_composer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .ax_i       (ax_i),
    .ay_i       (ay_i),
    .az_i       (az_i),
    .fx_i       (fx_i),
    .fy_i       (fy_i),
    .fz_i       (fz_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------- matrix predictor ----------------

  function automatic wide_t widen(input word_t w);
    wide_t e;
    e = w;
    return e;
  endfunction

  function automatic word_t clamp_word(input wide_t v);
    if (v > WIDE_MAX) return W_MAX;
    if (v < WIDE_MIN) return W_MIN;
    return v[31:0];
  endfunction

  // floor(a*b / 2^FRAC), exact
  function automatic wide_t prod_floor(input word_t a, input word_t b);
    wide_t p;
    p = widen(a) * widen(b);
    return p >>> FRAC;
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 12; i++) composite[i] = '0;
    for (int r = 0; r < 3; r++) composite[4 * r + r] = Q_ONE;
  endtask

  task automatic compose_transform(input xform_cmd_t cmd);
    word_t a[3];
    word_t f[3];
    word_t dterm;
    wide_t kterm;
    wide_t acc;
    word_t res[3];
    a[0] = cmd.ax; a[1] = cmd.ay; a[2] = cmd.az;
    f[0] = cmd.fx; f[1] = cmd.fy; f[2] = cmd.fz;
    case (cmd.kind)
      KIND_IDENT: begin
        load_identity();
      end
      KIND_TRANS: begin
        for (int r = 0; r < 3; r++)
          composite[4 * r + 3] = clamp_word(widen(composite[4 * r + 3]) + widen(a[r]));
      end
      KIND_SCALE: begin
        for (int r = 0; r < 3; r++) begin
          // fixed-point term (1 - s) * f keeps the pivot in place
          dterm = clamp_word(UNIT - widen(a[r]));
          kterm = widen(clamp_word(prod_floor(dterm, f[r])));
          for (int col = 0; col < 3; col++)
            composite[4 * r + col] = clamp_word(prod_floor(a[r], composite[4 * r + col]));
          composite[4 * r + 3] = clamp_word(prod_floor(a[r], composite[4 * r + 3]) + kterm);
        end
      end
      default: begin
        for (int r = 0; r < 3; r++) begin
          acc = '0;
          for (int col = 0; col < 3; col++)
            acc = acc + widen(composite[4 * r + col]) * widen(a[col]);
          res[r] = clamp_word((acc >>> FRAC) + widen(composite[4 * r + 3]));
        end
        expected_coords.push_back('{x: res[0], y: res[1], z: res[2]});
      end
    endcase
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic xform_cmd_t mk_cmd(input kind_e k, input word_t x, input word_t y,
                                        input word_t z, input word_t px, input word_t py,
                                        input word_t pz, input logic drain);
    xform_cmd_t c;
    c.kind = k;
    c.ax = x; c.ay = y; c.az = z;
    c.fx = px; c.fy = py; c.fz = pz;
    c.drain = drain;
    return c;
  endfunction

  function automatic word_t rnd_q(input int unsigned spread);
    return word_t'(int'($urandom_range(0, 2 * spread)) - int'(spread));
  endfunction

  function automatic word_t rnd_edge();
    case ($urandom_range(0, 11))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return Q_ONE;
      4: return -Q_ONE;
      5: return 32'sd1;
      6: return -32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t rnd_val(input int unsigned spread);
    if ($urandom_range(0, 9) == 0) return rnd_edge();
    return rnd_q(spread);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 45;
    endcase
  endfunction

  task automatic check_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("out_%s wrong: expected %0d (%08h), got %0d (%08h)",
                 name, want, want, got, got);
    end
  endtask

  // ---------------- driver ----------------

  always @(negedge clk_i) begin
    xform_cmd_t next_cmd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_accepted) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].drain && expected_coords.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > TAIL_ITEMS &&
                   $urandom_range(0, 99) < in_idle_pct) begin
        in_valid_i <= 1'b0;
        in_gap = $urandom_range(0, 5);
      end else begin
        next_cmd = pending_cmds.pop_front();
        kind_i <= next_cmd.kind;
        ax_i <= next_cmd.ax;
        ay_i <= next_cmd.ay;
        az_i <= next_cmd.az;
        fx_i <= next_cmd.fx;
        fy_i <= next_cmd.fy;
        fz_i <= next_cmd.fz;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 149) == 0) in_idle_pct = pick_pct();
      end
    end
  end

  // ---------------- receiver ----------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_gap != 0) begin
      out_ready_i <= 1'b0;
      out_gap--;
    end else if (pending_cmds.size() > TAIL_ITEMS &&
                 $urandom_range(0, 99) < out_idle_pct) begin
      out_ready_i <= 1'b0;
      out_gap = $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) == 0) out_idle_pct = pick_pct();
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk_i) begin
    coord_t want;
    in_accepted = rst_ni && in_valid_i && in_ready_o;
    // results first: a result taken now belongs to an earlier vertex
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: %0d %0d %0d", out_x_o, out_y_o, out_z_o);
      end else begin
        want = expected_coords.pop_front();
        check_field("x", want.x, out_x_o);
        check_field("y", want.y, out_y_o);
        check_field("z", want.z, out_z_o);
      end
    end
    if (in_accepted)
      compose_transform(mk_cmd(kind_e'(kind_i), ax_i, ay_i, az_i, fx_i, fy_i, fz_i, 1'b0));
  end

  // ---------------- watchdog ----------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("affine_transform_composer_top: mismatch");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    logic drain;
    load_identity();

    // directed: identity, saturation, pivots, zero and negative scales
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, Q_ONE, 32'shfffd_8000, 32'sh0003_0000,
                                  W_MAX, W_MIN, 32'sh1234_5678, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, W_MAX, W_MIN, 0, W_MIN, W_MAX, -1, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_TRANS, Q_ONE, 2 * Q_ONE, -3 * Q_ONE,
                                  W_MAX, W_MAX, W_MAX, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, 0, 0, 0, 0, 0, 0, 1'b1));
    pending_cmds.push_back(mk_cmd(KIND_TRANS, W_MAX, W_MAX, W_MIN, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, -Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_IDENT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_SCALE, 2 * Q_ONE, 32'sh0000_8000, -Q_ONE,
                                  Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, Q_ONE, Q_ONE, Q_ONE, W_MAX, 0, 0, 1'b1));
    pending_cmds.push_back(mk_cmd(KIND_SCALE, W_MIN, W_MAX, 0, W_MAX, W_MIN, W_MAX, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, W_MAX, W_MIN, W_MAX, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, W_MIN, W_MIN, W_MIN, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_IDENT, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_TRANS, W_MIN, W_MIN, W_MAX, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_SCALE, -1, 1, Q_ONE, W_MIN, W_MAX, -Q_ONE, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, 1, -1, 0, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_IDENT, 0, 0, 0, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_SCALE, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, W_MAX, W_MAX, W_MAX, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_IDENT, -1, -1, -1, -1, -1, -1, 1'b0));
    pending_cmds.push_back(mk_cmd(KIND_VERTEX, -1, -1, -1, -1, -1, -1, 1'b1));

    // random scenes: mostly identity, a few transforms, then vertices
    while (pending_cmds.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        drain = ($urandom_range(0, 7) == 0);
        pending_cmds.push_back(mk_cmd(KIND_IDENT, rnd_edge(), rnd_edge(), rnd_edge(),
                                      rnd_edge(), rnd_edge(), rnd_edge(), drain));
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1) == 0)
            pending_cmds.push_back(mk_cmd(KIND_TRANS, rnd_val(32'd65536000),
                                          rnd_val(32'd65536000), rnd_val(32'd65536000),
                                          rnd_edge(), rnd_edge(), rnd_edge(), 1'b0));
          else
            pending_cmds.push_back(mk_cmd(KIND_SCALE, rnd_val(32'd262144),
                                          rnd_val(32'd262144), rnd_val(32'd262144),
                                          rnd_val(32'd65536000), rnd_val(32'd65536000),
                                          rnd_val(32'd65536000), 1'b0));
        end
        repeat ($urandom_range(1, 6))
          pending_cmds.push_back(mk_cmd(KIND_VERTEX, rnd_val(32'd65536000),
                                        rnd_val(32'd65536000), rnd_val(32'd65536000),
                                        rnd_edge(), rnd_edge(), rnd_edge(), 1'b0));
      end else begin
        repeat ($urandom_range(1, 4))
          pending_cmds.push_back(mk_cmd(kind_e'($urandom_range(0, 3)), rnd_edge(),
                                        rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge(),
                                        rnd_edge(), 1'b0));
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid_i || expected_coords.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("affine_transform_composer_top: match");
    end else begin
      $display("affine_transform_composer_top: mismatch");
    end
    $finish;
  end

endmodule
